### hw/rtl/rnp_pkg.sv
// ----------------------------------------------------------------------------
// rnp_pkg
// Shared types and constants of the radius neighbor pair finder.
// ----------------------------------------------------------------------------
`default_nettype none

package rnp_pkg;

  // Width of the radius register and of its square.
  localparam int RADIUS_W = 16;
  localparam int RSQ_W    = 2 * RADIUS_W;

  // Input commands.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Status of the distance pipeline as seen by the controller.
  typedef struct packed {
    logic hit;   // last stage holds a neighbor of the new point
    logic busy;  // any stage still holds a comparison
  } pipe_status_t;

endpackage

`default_nettype wire

### hw/rtl/radius_neighbor_pairs.sv
// ----------------------------------------------------------------------------
// radius_neighbor_pairs
// Fixed-radius near neighbor search in two dimensions. Each added point is
// stored and compared with all earlier points; every pair closer than the
// radius is reported once, when its later point arrives.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Contents
//   in_      input      in_valid / in_ready    command, x_coord, y_coord
//   out_     output     out_valid / out_ready  point_index, partner_index,
//                                              is_pair, store_full, last
//   cfg_     input      cfg_wr_en              radius, no wait
//
// An add request with n >= 1 stored points reads them in order, one stored
// point per cycle into a three-deep compare pipeline unless a held pair waits
// for the output, and posts its final result once the pipeline has drained.
// Clear, store-full and first-point requests go straight to the final result.
// Reset is synchronous: the store becomes empty and the radius zero.
// A new request is taken while the previous final result still waits.
// The scan pauses while a found pair waits behind an output that is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module radius_neighbor_pairs #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_command,
  input  wire logic signed [COORD_BITS-1:0]  in_x_coord,
  input  wire logic signed [COORD_BITS-1:0]  in_y_coord,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [$clog2(MAX_POINTS)-1:0]      out_point_index,
  output logic [$clog2(MAX_POINTS)-1:0]      out_partner_index,
  output logic                               out_is_pair,
  output logic                               out_store_full,
  output logic                               out_last,
  input  wire logic                          cfg_wr_en,
  input  wire logic [rnp_pkg::RADIUS_W-1:0]  cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PT_W  = 2 * COORD_BITS;

  rnp_pkg::state_t       state_r, state_nxt;
  rnp_pkg::pipe_status_t pstat;

  logic [rnp_pkg::RADIUS_W-1:0] radius_r;
  logic [rnp_pkg::RSQ_W-1:0]    rsq_r;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      issue_cnt_r, issue_cnt_nxt;
  logic [IDX_W-1:0]      cur_idx_r;
  logic                  clr_r, full_r;
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r;

  logic                  s0_vld_r;
  logic [IDX_W-1:0]      s0_idx_r;
  logic [PT_W-1:0]       rd_data;
  logic [IDX_W-1:0]      hit_idx;

  logic                  pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]      pend_idx_r, pend_idx_nxt;

  logic                  out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0]      out_pt_r, out_pt_nxt, out_pa_r, out_pa_nxt;
  logic                  out_pair_r, out_pair_nxt, out_full_r, out_full_nxt;
  logic                  out_last_r, out_last_nxt;

  logic accept, has_room, add_ok, issuing, adv, out_free, load_pair, load_done;

  assign in_ready  = (state_r == rnp_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign has_room  = (count_r < CNT_W'(MAX_POINTS));
  assign add_ok    = accept && (in_command == rnp_pkg::CMD_ADD) && has_room;
  assign issuing   = (state_r == rnp_pkg::ST_SCAN) && (issue_cnt_r < CNT_W'(cur_idx_r));
  assign out_free  = !out_vld_r || out_ready;
  // A held pair can only move on into a free output register.
  assign adv       = !(pend_vld_r && !out_free);
  assign load_pair = adv && pstat.hit && pend_vld_r;
  assign load_done = (state_r == rnp_pkg::ST_DONE) && out_free;

  // The new point is written at acceptance, before the scan reads anything,
  // and the scan only reads lower entries, so the ports never collide.
  rnp_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (IDX_W),
    .DW    (PT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (add_ok),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({in_x_coord, in_y_coord}),
    .rd_en   (adv && issuing),
    .rd_addr (issue_cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  rnp_dist_pipe #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (s0_vld_r),
    .in_idx  (s0_idx_r),
    .new_x   (cur_x_r),
    .new_y   (cur_y_r),
    .old_x   (rd_data[PT_W-1:COORD_BITS]),
    .old_y   (rd_data[COORD_BITS-1:0]),
    .radius  (radius_r),
    .rsq     (rsq_r),
    .status  (pstat),
    .hit_idx (hit_idx)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rnp_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_command == rnp_pkg::CMD_CLEAR) || !has_room || (count_r == '0)) begin
            state_nxt = rnp_pkg::ST_DONE;
          end else begin
            state_nxt = rnp_pkg::ST_SCAN;
          end
        end
      end
      rnp_pkg::ST_SCAN: begin
        if (!issuing && !pstat.busy) begin
          state_nxt = rnp_pkg::ST_DONE;
        end
      end
      rnp_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = rnp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rnp_pkg::ST_IDLE;
    endcase
  end

  // Counters and the held pair.
  always_comb begin
    count_nxt     = count_r;
    issue_cnt_nxt = issue_cnt_r;
    pend_vld_nxt  = pend_vld_r;
    pend_idx_nxt  = pend_idx_r;
    if (accept) begin
      issue_cnt_nxt = '0;
      pend_vld_nxt  = 1'b0;
      if (in_command == rnp_pkg::CMD_CLEAR) begin
        count_nxt = '0;
      end else if (has_room) begin
        count_nxt = count_r + 1'b1;
      end
    end
    if (adv && issuing) begin
      issue_cnt_nxt = issue_cnt_r + 1'b1;
    end
    // The newest pair is held back until it is known whether it is the last.
    if (adv && pstat.hit) begin
      pend_vld_nxt = 1'b1;
      pend_idx_nxt = hit_idx;
    end
  end

  // Output register.
  always_comb begin
    out_vld_nxt  = out_ready ? 1'b0 : out_vld_r;
    out_pt_nxt   = out_pt_r;
    out_pa_nxt   = out_pa_r;
    out_pair_nxt = out_pair_r;
    out_full_nxt = out_full_r;
    out_last_nxt = out_last_r;
    if (load_pair) begin
      out_vld_nxt  = 1'b1;
      out_pt_nxt   = cur_idx_r;
      out_pa_nxt   = pend_idx_r;
      out_pair_nxt = 1'b1;
      out_full_nxt = 1'b0;
      out_last_nxt = 1'b0;
    end else if (load_done) begin
      out_vld_nxt  = 1'b1;
      out_last_nxt = 1'b1;
      out_full_nxt = full_r;
      if (clr_r || full_r) begin
        out_pt_nxt   = '0;
        out_pa_nxt   = '0;
        out_pair_nxt = 1'b0;
      end else if (pend_vld_r) begin
        out_pt_nxt   = cur_idx_r;
        out_pa_nxt   = pend_idx_r;
        out_pair_nxt = 1'b1;
      end else begin
        out_pt_nxt   = cur_idx_r;
        out_pa_nxt   = '0;
        out_pair_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rnp_pkg::ST_IDLE;
      radius_r    <= '0;
      count_r     <= '0;
      issue_cnt_r <= '0;
      s0_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
      if (adv) begin
        s0_vld_r <= issuing;
      end
    end
  end

  always_ff @(posedge clk) begin
    rsq_r      <= radius_r * radius_r;
    pend_idx_r <= pend_idx_nxt;
    out_pt_r   <= out_pt_nxt;
    out_pa_r   <= out_pa_nxt;
    out_pair_r <= out_pair_nxt;
    out_full_r <= out_full_nxt;
    out_last_r <= out_last_nxt;
    if (adv) begin
      s0_idx_r <= issue_cnt_r[IDX_W-1:0];
    end
    if (accept) begin
      cur_idx_r <= count_r[IDX_W-1:0];
      clr_r     <= (in_command == rnp_pkg::CMD_CLEAR);
      full_r    <= (in_command == rnp_pkg::CMD_ADD) && !has_room;
      cur_x_r   <= in_x_coord;
      cur_y_r   <= in_y_coord;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_point_index   = out_pt_r;
  assign out_partner_index = out_pa_r;
  assign out_is_pair       = out_pair_r;
  assign out_store_full    = out_full_r;
  assign out_last          = out_last_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count above store depth");

  a_add_counts : assert property (@(posedge clk) disable iff (!rst_n)
    add_ok |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted add did not grow the store");

  a_scan_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rnp_pkg::ST_SCAN) |-> issue_cnt_r <= CNT_W'(cur_idx_r))
    else $error("scan read past the new point");

  a_partner_earlier : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_pair_r) |-> (out_pa_r < out_pt_r) && !out_full_r)
    else $error("pair result with a partner that is not earlier");

endmodule

`default_nettype wire

### hw/rtl/rnp_point_mem.sv
// ----------------------------------------------------------------------------
// rnp_point_mem
// Point store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_point_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rnp_dist_pipe.sv
// ----------------------------------------------------------------------------
// rnp_dist_pipe
// Two-stage distance check of the new point against one stored point per
// cycle while adv holds: absolute differences and box test, then squares,
// then the sum is compared against the squared radius.
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_dist_pipe #(
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        in_vld,
  input  wire logic [IDX_W-1:0]            in_idx,
  input  wire logic [COORD_BITS-1:0]       new_x,
  input  wire logic [COORD_BITS-1:0]       new_y,
  input  wire logic [COORD_BITS-1:0]       old_x,
  input  wire logic [COORD_BITS-1:0]       old_y,
  input  wire logic [rnp_pkg::RADIUS_W-1:0] radius,
  input  wire logic [rnp_pkg::RSQ_W-1:0]    rsq,
  output rnp_pkg::pipe_status_t            status,
  output logic      [IDX_W-1:0]            hit_idx
);

  localparam int D_W   = COORD_BITS + 1;
  localparam int R_W   = rnp_pkg::RADIUS_W;
  localparam int CMP_W = (D_W > R_W) ? D_W : R_W;
  localparam int SQ_W  = rnp_pkg::RSQ_W;

  logic [D_W-1:0]   dx_diff, dy_diff, dx_abs, dy_abs;
  logic [CMP_W-1:0] dx_ext, dy_ext, r_ext;
  logic             near;

  logic             s1_vld_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_near_r;
  logic [R_W-1:0]   s1_dx_r, s1_dy_r;

  logic             s2_vld_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic             s2_near_r;
  logic [SQ_W-1:0]  s2_dxsq_r, s2_dysq_r;
  logic [SQ_W:0]    sum;

  // The true difference of two COORD_BITS values always fits in D_W bits.
  assign dx_diff = {new_x[COORD_BITS-1], new_x} - {old_x[COORD_BITS-1], old_x};
  assign dy_diff = {new_y[COORD_BITS-1], new_y} - {old_y[COORD_BITS-1], old_y};
  assign dx_abs  = dx_diff[D_W-1] ? (~dx_diff + 1'b1) : dx_diff;
  assign dy_abs  = dy_diff[D_W-1] ? (~dy_diff + 1'b1) : dy_diff;
  assign dx_ext  = CMP_W'(dx_abs);
  assign dy_ext  = CMP_W'(dy_abs);
  assign r_ext   = CMP_W'(radius);
  // Both offsets below the radius bounds them to the radius width, so the
  // squares below need only radius-wide operands.
  assign near    = (dx_ext < r_ext) && (dy_ext < r_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx_r  <= in_idx;
      s1_near_r <= near;
      s1_dx_r   <= dx_ext[R_W-1:0];
      s1_dy_r   <= dy_ext[R_W-1:0];
      s2_idx_r  <= s1_idx_r;
      s2_near_r <= s1_near_r;
      s2_dxsq_r <= s1_dx_r * s1_dx_r;
      s2_dysq_r <= s1_dy_r * s1_dy_r;
    end
  end

  assign sum         = {1'b0, s2_dxsq_r} + {1'b0, s2_dysq_r};
  assign status.hit  = s2_vld_r && s2_near_r && (sum < {1'b0, rsq});
  assign status.busy = in_vld || s1_vld_r || s2_vld_r;
  assign hit_idx     = s2_idx_r;

endmodule

`default_nettype wire
